@@ hdl/spcr_pkg.sv @@
// Shared widths, payload types and helpers for the sphere pair collide and resolve block.
`timescale 1ns / 1ps

package spcr_pkg;

    localparam int COORD_W = 32;
    localparam int RAD_W   = 31;
    localparam int MAG_W   = 32;
    localparam int SUM_W   = 32;
    localparam int PROD_W  = 64;
    localparam int SQS_W   = 66;
    localparam int ROOT_W  = 33;
    localparam int DEN_W   = 34;
    localparam int NUM_W   = 64;
    localparam int QUO_W   = 32;
    localparam int IN_W    = 256;
    localparam int OUT_W   = 200;

    // Payload that rides alongside the square root and divider pipelines
    typedef struct packed {
        logic [2:0][COORD_W-1:0] p1;
        logic [2:0][COORD_W-1:0] p2;
        logic [2:0]              neg;
        logic                    collided;
        logic                    moved;
    } side_t;

    // Clamp a 34 bit signed value into signed 32 bits
    function automatic logic [COORD_W-1:0] sat32(input logic signed [COORD_W+1:0] v);
        logic signed [COORD_W+1:0] hi;
        logic signed [COORD_W+1:0] lo;
        hi = (COORD_W+2)'(34'sh0_7FFF_FFFF);
        lo = -(COORD_W+2)'(34'sh0_8000_0000);
        if (v > hi)
        begin
            return {1'b0, {(COORD_W-1){1'b1}}};
        end
        else if (v < lo)
        begin
            return {1'b1, {(COORD_W-1){1'b0}}};
        end
        return v[COORD_W-1:0];
    endfunction

endpackage

@@ hdl/spcr_isqrt.sv @@
// Pipelined integer square root, one root bit per stage.
`timescale 1ns / 1ps

module spcr_isqrt
(
    input  logic                         clk,
    input  logic                         en,
    input  logic [spcr_pkg::SQS_W-1:0]   value,
    output logic [spcr_pkg::ROOT_W-1:0]  root
);

    localparam int SW = spcr_pkg::SQS_W;
    localparam int RW = spcr_pkg::ROOT_W;
    localparam int TW = SW + 2;

    logic [RW-1:0] root_reg [RW];
    logic [TW-1:0] sq_reg   [RW];
    logic [SW-1:0] val_reg  [RW];

    genvar k;
    generate
        for (k = 0; k < RW; k++)
        begin : g_stage
            localparam int B = RW - 1 - k;
            logic [RW-1:0] root_in;
            logic [TW-1:0] sq_in;
            logic [SW-1:0] val_in;
            logic [TW-1:0] trial;
            logic          take;

            // Pick the previous stage or the pipeline input
            if (k == 0)
            begin : g_first
                assign root_in = '0;
                assign sq_in   = '0;
                assign val_in  = value;
            end
            else
            begin : g_next
                assign root_in = root_reg[k-1];
                assign sq_in   = sq_reg[k-1];
                assign val_in  = val_reg[k-1];
            end

            // Square of the trial root grown from the current square
            always_comb
            begin
                trial = sq_in + (TW'(root_in) << (B + 1)) + (TW'(1) << (2 * B));
                take  = (trial <= TW'(val_in));
            end

            // Advance one bit of the root
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    val_reg[k]  <= val_in;
                    root_reg[k] <= take ? (root_in | (RW'(1) << B)) : root_in;
                    sq_reg[k]   <= take ? trial : sq_in;
                end
            end
        end
    endgenerate

    assign root = root_reg[RW-1];

endmodule

@@ hdl/spcr_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps

module spcr_div
(
    input  logic                        clk,
    input  logic                        en,
    input  logic [spcr_pkg::NUM_W-1:0]  num,
    input  logic [spcr_pkg::DEN_W-1:0]  den,
    output logic [spcr_pkg::QUO_W-1:0]  quo
);

    localparam int NW = spcr_pkg::NUM_W;
    localparam int DW = spcr_pkg::DEN_W;
    localparam int QW = spcr_pkg::QUO_W;
    localparam int CW = NW + 2;

    logic [NW-1:0] rem_reg [QW];
    logic [DW-1:0] den_reg [QW];
    logic [QW-1:0] quo_reg [QW];

    genvar k;
    generate
        for (k = 0; k < QW; k++)
        begin : g_stage
            localparam int B = QW - 1 - k;
            logic [NW-1:0] rem_in;
            logic [DW-1:0] den_in;
            logic [QW-1:0] quo_in;
            logic [CW-1:0] shifted;
            logic          take;

            // Pick the previous stage or the pipeline input
            if (k == 0)
            begin : g_first
                assign rem_in = num;
                assign den_in = den;
                assign quo_in = '0;
            end
            else
            begin : g_next
                assign rem_in = rem_reg[k-1];
                assign den_in = den_reg[k-1];
                assign quo_in = quo_reg[k-1];
            end

            always_comb
            begin
                shifted = CW'(den_in) << B;
                take    = (CW'(rem_in) >= shifted);
            end

            // Subtract the shifted divisor when it fits
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    den_reg[k] <= den_in;
                    rem_reg[k] <= take ? (rem_in - shifted[NW-1:0]) : rem_in;
                    quo_reg[k] <= take ? (quo_in | (QW'(1) << B)) : quo_in;
                end
            end
        end
    endgenerate

    assign quo = quo_reg[QW-1];

endmodule

@@ hdl/sphere_pair_collide_resolve.sv @@
// Top level of the sphere pair collide and resolve pipeline.
`timescale 1ns / 1ps

// One sphere pair enters per cycle unless the pipeline holds; it passes through
// the input stage, magnitude, square, sum, 33 square root stages, overlap,
// product, rounding add, 32 divider stages and output register. The length is
// set by the bit-per-stage square root and the bit-per-stage dividers. The
// whole pipeline holds as one while the output word waits; s_tready is low
// exactly then. Coordinates are raw signed fixed point; the results do not
// depend on where the binary point sits.
module sphere_pair_collide_resolve
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // first_x, first_y, first_z, second_x, second_y, second_z,
    // first_radius, second_radius, zero pad
    input  logic [spcr_pkg::IN_W-1:0]    s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // collided, moved, new_first_x, new_first_y, new_first_z,
    // new_second_x, new_second_y, new_second_z, zero pad
    output logic [spcr_pkg::OUT_W-1:0]   m_tdata
);

    localparam int CW = spcr_pkg::COORD_W;
    localparam int RL = spcr_pkg::ROOT_W;
    localparam int QL = spcr_pkg::QUO_W;

    logic adv;

    // Stage 0: input word
    logic                 v0_reg;
    logic [2:0][CW-1:0]   p1_0_reg, p2_0_reg;
    logic [spcr_pkg::RAD_W-1:0] r1_0_reg, r2_0_reg;

    // Stage 1: magnitudes and radius sum
    logic                 v1_reg;
    spcr_pkg::side_t      sd1_reg;
    logic [2:0][spcr_pkg::MAG_W-1:0] mag1_reg;
    logic [spcr_pkg::SUM_W-1:0] rsum1_reg;

    // Stage 2: squares
    logic                 v2_reg;
    spcr_pkg::side_t      sd2_reg;
    logic [2:0][spcr_pkg::MAG_W-1:0] mag2_reg;
    logic [spcr_pkg::SUM_W-1:0] rsum2_reg;
    logic [2:0][spcr_pkg::PROD_W-1:0] sq2_reg;
    logic [spcr_pkg::PROD_W-1:0] rsq2_reg;

    // Stage 3: squared distance and flags
    logic                 v3_reg;
    spcr_pkg::side_t      sd3_reg;
    logic [2:0][spcr_pkg::MAG_W-1:0] mag3_reg;
    logic [spcr_pkg::SUM_W-1:0] rsum3_reg;
    logic [spcr_pkg::SQS_W-1:0] s3_reg;

    // Delay line beside the square root
    logic                 vr_reg   [RL];
    spcr_pkg::side_t      sdr_reg  [RL];
    logic [2:0][spcr_pkg::MAG_W-1:0] magr_reg [RL];
    logic [spcr_pkg::SUM_W-1:0] rsumr_reg [RL];
    logic [RL-1:0]        root;

    // Stage 4: overlap
    logic                 v4_reg;
    spcr_pkg::side_t      sd4_reg;
    logic [2:0][spcr_pkg::MAG_W-1:0] mag4_reg;
    logic [RL-1:0]        dist4_reg;
    logic [spcr_pkg::SUM_W-1:0] ov4_reg;

    // Stage 5: products
    logic                 v5_reg;
    spcr_pkg::side_t      sd5_reg;
    logic [RL-1:0]        dist5_reg;
    logic [2:0][spcr_pkg::PROD_W-1:0] num5_reg;

    // Stage 6: rounding add
    logic                 v6_reg;
    spcr_pkg::side_t      sd6_reg;
    logic [spcr_pkg::DEN_W-1:0] den6_reg;
    logic [2:0][spcr_pkg::NUM_W-1:0] num6_reg;

    // Delay line beside the dividers
    logic                 vq_reg  [QL];
    spcr_pkg::side_t      sdq_reg [QL];
    logic [2:0][QL-1:0]   quo;

    // Output register
    logic                 out_valid_reg;
    logic                 collided_reg, moved_reg;
    logic [2:0][CW-1:0]   n1_reg, n2_reg;

    // Move every stage together unless the output word is held
    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = adv;

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg        <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            v6_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < RL; i++)
            begin
                vr_reg[i] <= 1'b0;
            end
            for (int i = 0; i < QL; i++)
            begin
                vq_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            v0_reg    <= s_tvalid;
            v1_reg    <= v0_reg;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            vr_reg[0] <= v3_reg;
            for (int i = 1; i < RL; i++)
            begin
                vr_reg[i] <= vr_reg[i-1];
            end
            v4_reg    <= vr_reg[RL-1];
            v5_reg    <= v4_reg;
            v6_reg    <= v5_reg;
            vq_reg[0] <= v6_reg;
            for (int i = 1; i < QL; i++)
            begin
                vq_reg[i] <= vq_reg[i-1];
            end
            out_valid_reg <= vq_reg[QL-1];
        end
    end

    // Front stages: unpack, deltas, squares, sum and compare
    always_ff @(posedge clk)
    begin
        logic signed [CW:0] dl;
        logic [spcr_pkg::SQS_W-1:0] s_next;
        logic coll_next;
        spcr_pkg::side_t sd3_next;
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                p1_0_reg[i] <= s_tdata[i*CW +: CW];
                p2_0_reg[i] <= s_tdata[(3+i)*CW +: CW];
            end
            r1_0_reg <= s_tdata[6*CW +: spcr_pkg::RAD_W];
            r2_0_reg <= s_tdata[6*CW+spcr_pkg::RAD_W +: spcr_pkg::RAD_W];

            sd1_reg.p1       <= p1_0_reg;
            sd1_reg.p2       <= p2_0_reg;
            sd1_reg.collided <= 1'b0;
            sd1_reg.moved    <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                dl = $signed({p2_0_reg[i][CW-1], p2_0_reg[i]})
                   - $signed({p1_0_reg[i][CW-1], p1_0_reg[i]});
                sd1_reg.neg[i] <= dl[CW];
                mag1_reg[i]    <= dl[CW] ? spcr_pkg::MAG_W'(-dl) : spcr_pkg::MAG_W'(dl);
            end
            rsum1_reg <= spcr_pkg::SUM_W'(r1_0_reg) + spcr_pkg::SUM_W'(r2_0_reg);

            sd2_reg   <= sd1_reg;
            mag2_reg  <= mag1_reg;
            rsum2_reg <= rsum1_reg;
            for (int i = 0; i < 3; i++)
            begin
                sq2_reg[i] <= spcr_pkg::PROD_W'(mag1_reg[i]) * spcr_pkg::PROD_W'(mag1_reg[i]);
            end
            rsq2_reg <= spcr_pkg::PROD_W'(rsum1_reg) * spcr_pkg::PROD_W'(rsum1_reg);

            s_next = spcr_pkg::SQS_W'(sq2_reg[0]) + spcr_pkg::SQS_W'(sq2_reg[1])
                   + spcr_pkg::SQS_W'(sq2_reg[2]);
            coll_next = (s_next <= spcr_pkg::SQS_W'(rsq2_reg));
            sd3_next          = sd2_reg;
            sd3_next.collided = coll_next;
            sd3_next.moved    = coll_next && (s_next != spcr_pkg::SQS_W'(rsq2_reg))
                                && (s_next != '0);
            sd3_reg   <= sd3_next;
            mag3_reg  <= mag2_reg;
            rsum3_reg <= rsum2_reg;
            s3_reg    <= s_next;
        end
    end

    spcr_isqrt u_isqrt
    (
        .clk   (clk),
        .en    (adv),
        .value (s3_reg),
        .root  (root)
    );

    // Carry the payload beside the square root
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sdr_reg[0]   <= sd3_reg;
            magr_reg[0]  <= mag3_reg;
            rsumr_reg[0] <= rsum3_reg;
            for (int i = 1; i < RL; i++)
            begin
                sdr_reg[i]   <= sdr_reg[i-1];
                magr_reg[i]  <= magr_reg[i-1];
                rsumr_reg[i] <= rsumr_reg[i-1];
            end
        end
    end

    // Overlap, products and rounding add
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sd4_reg   <= sdr_reg[RL-1];
            mag4_reg  <= magr_reg[RL-1];
            dist4_reg <= root;
            ov4_reg   <= rsumr_reg[RL-1] - root[spcr_pkg::SUM_W-1:0];

            sd5_reg   <= sd4_reg;
            dist5_reg <= dist4_reg;
            for (int i = 0; i < 3; i++)
            begin
                num5_reg[i] <= spcr_pkg::PROD_W'(mag4_reg[i]) * spcr_pkg::PROD_W'(ov4_reg);
            end

            sd6_reg  <= sd5_reg;
            den6_reg <= {dist5_reg, 1'b0};
            for (int i = 0; i < 3; i++)
            begin
                num6_reg[i] <= num5_reg[i] + spcr_pkg::NUM_W'(dist5_reg);
            end
        end
    end

    genvar a;
    generate
        for (a = 0; a < 3; a++)
        begin : g_axis
            spcr_div u_div
            (
                .clk (clk),
                .en  (adv),
                .num (num6_reg[a]),
                .den (den6_reg),
                .quo (quo[a])
            );
        end
    endgenerate

    // Carry the payload beside the dividers
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sdq_reg[0] <= sd6_reg;
            for (int i = 1; i < QL; i++)
            begin
                sdq_reg[i] <= sdq_reg[i-1];
            end
        end
    end

    // Apply the push and saturate
    always_ff @(posedge clk)
    begin
        logic signed [CW+1:0] d;
        logic signed [CW+1:0] c1;
        logic signed [CW+1:0] c2;
        if (adv)
        begin
            collided_reg <= sdq_reg[QL-1].collided;
            moved_reg    <= sdq_reg[QL-1].moved;
            for (int i = 0; i < 3; i++)
            begin
                d  = $signed({2'b00, quo[i]});
                c1 = $signed({{2{sdq_reg[QL-1].p1[i][CW-1]}}, sdq_reg[QL-1].p1[i]});
                c2 = $signed({{2{sdq_reg[QL-1].p2[i][CW-1]}}, sdq_reg[QL-1].p2[i]});
                if (sdq_reg[QL-1].neg[i])
                begin
                    d = -d;
                end
                if (sdq_reg[QL-1].moved)
                begin
                    n1_reg[i] <= spcr_pkg::sat32(c1 - d);
                    n2_reg[i] <= spcr_pkg::sat32(c2 + d);
                end
                else
                begin
                    n1_reg[i] <= sdq_reg[QL-1].p1[i];
                    n2_reg[i] <= sdq_reg[QL-1].p2[i];
                end
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, n2_reg[2], n2_reg[1], n2_reg[0],
                       n1_reg[2], n1_reg[1], n1_reg[0], moved_reg, collided_reg};

    // A held output word must block the input side
    a_hold_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input accepted while output word held");

    // Pushing apart only happens on a collision
    a_moved_collided: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && moved_reg) |-> collided_reg)
        else $error("moved without collision");

    // A word leaving the last divider stage lands in the output register
    a_valid_flow: assert property (@(posedge clk) disable iff (!rst_n)
        (vq_reg[QL-1] && adv) |=> out_valid_reg)
        else $error("result lost at output register");

endmodule

@@ tb/sphere_pair_collide_resolve_tb.sv @@
// Self-checking testbench for the sphere pair collide and resolve pipeline.
`timescale 1ns / 1ps

module sphere_pair_collide_resolve_tb;

    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_WAIT  = 100;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 1100;

    typedef struct {
        logic signed [spcr_pkg::COORD_W-1:0] p1 [3];
        logic signed [spcr_pkg::COORD_W-1:0] p2 [3];
        logic [spcr_pkg::RAD_W-1:0]          r1;
        logic [spcr_pkg::RAD_W-1:0]          r2;
    } pair_t;

    typedef struct {
        logic                                collided;
        logic                                moved;
        logic signed [spcr_pkg::COORD_W-1:0] n1 [3];
        logic signed [spcr_pkg::COORD_W-1:0] n2 [3];
    } resolved_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [spcr_pkg::IN_W-1:0]     s_tdata = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [spcr_pkg::OUT_W-1:0]    m_tdata;

    resolved_t pending_q [$];
    int        mismatches = 0;
    int        cycles = 0;
    bit        rx_stall_on = 1'b0;
    int        hold_reqs = 0;
    int        hold_seen = 0;
    int        hold_cnt = 0;
    int        rx_run = 0;
    bit        rx_state = 1'b1;

    sphere_pair_collide_resolve i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    // End the run on a hung pipeline
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Clamp to signed 32 bits
    function automatic logic signed [spcr_pkg::COORD_W-1:0] clamp32(input longint v);
        if (v > 64'sh7FFF_FFFF)
            return 32'sh7FFF_FFFF;
        if (v < -64'sh8000_0000)
            return 32'sh8000_0000;
        return v[spcr_pkg::COORD_W-1:0];
    endfunction

    // Compute the collision flags and the pushed-apart centers of one pair
    function automatic resolved_t resolve_pair(input pair_t a);
        resolved_t   r;
        longint      dl [3];
        logic [127:0] mg [3];
        logic [127:0] sq, rsum, rsq, root, c, overlap, q;
        longint      d;
        int          i;
        sq = '0;
        for (i = 0; i < 3; i++)
        begin
            dl[i] = longint'(a.p2[i]) - longint'(a.p1[i]);
            mg[i] = (dl[i] < 0) ? 128'(-dl[i]) : 128'(dl[i]);
            sq = sq + mg[i] * mg[i];
            r.n1[i] = a.p1[i];
            r.n2[i] = a.p2[i];
        end
        rsum = 128'(a.r1) + 128'(a.r2);
        rsq = rsum * rsum;
        r.collided = (sq <= rsq);
        r.moved = r.collided && (sq != rsq) && (sq != 0);
        if (r.moved)
        begin
            root = '0;
            for (i = 33; i >= 0; i--)
            begin
                c = root | (128'd1 << i);
                if (c * c <= sq)
                    root = c;
            end
            overlap = rsum - root;
            for (i = 0; i < 3; i++)
            begin
                q = (mg[i] * overlap + root) / (root << 1);
                d = (dl[i] < 0) ? -longint'(q[62:0]) : longint'(q[62:0]);
                r.n1[i] = clamp32(longint'(a.p1[i]) - d);
                r.n2[i] = clamp32(longint'(a.p2[i]) + d);
            end
        end
        return r;
    endfunction

    // Drive one word and wait for it to be taken
    task automatic send_pair(input pair_t a);
        s_tdata <= {2'b00, a.r2, a.r1, a.p2[2], a.p2[1], a.p2[0], a.p1[2], a.p1[1], a.p1[0]};
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        pending_q.push_back(resolve_pair(a));
    endtask

    task automatic idle_gap(input int n);
        if (n > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
    endtask

    function automatic pair_t make_pair(input int ax, input int ay, input int az,
                                        input int bx, input int by, input int bz,
                                        input int ra, input int rb);
        pair_t a;
        a.p1[0] = ax; a.p1[1] = ay; a.p1[2] = az;
        a.p2[0] = bx; a.p2[1] = by; a.p2[2] = bz;
        a.r1 = ra[spcr_pkg::RAD_W-1:0];
        a.r2 = rb[spcr_pkg::RAD_W-1:0];
        return a;
    endfunction

    // Random pair: mostly near-overlapping spheres at a random scale
    function automatic pair_t random_pair();
        pair_t a;
        int    k, i;
        logic [31:0] m;
        k = $urandom_range(0, 30);
        m = (32'd1 << k) - 1;
        for (i = 0; i < 3; i++)
        begin
            a.p1[i] = $urandom;
            if ($urandom_range(0, 9) == 0)
                a.p2[i] = $urandom;
            else
                a.p2[i] = a.p1[i] + $signed(($urandom & m) - (m >> 1));
        end
        if ($urandom_range(0, 7) == 0)
        begin
            a.r1 = spcr_pkg::RAD_W'($urandom);
            a.r2 = spcr_pkg::RAD_W'($urandom);
        end
        else
        begin
            a.r1 = spcr_pkg::RAD_W'($urandom & (m << 1 | 1));
            a.r2 = spcr_pkg::RAD_W'($urandom & (m << 1 | 1));
        end
        if ($urandom_range(0, 40) == 0)
            a.p2 = a.p1;
        return a;
    endfunction

    // Receiver stall pattern and long hold-off counter
    always @(posedge clk)
    begin
        if (hold_reqs != hold_seen)
        begin
            hold_seen <= hold_reqs;
            hold_cnt <= HOLD_CYCLES;
        end
        else if (hold_cnt != 0)
        begin
            hold_cnt <= hold_cnt - 1;
        end
        if (rx_run == 0)
        begin
            rx_run <= $urandom_range(1, 12);
            rx_state <= ($urandom_range(0, 2) != 0);
        end
        else
        begin
            rx_run <= rx_run - 1;
        end
        m_tready <= (hold_cnt == 0) && (!rx_stall_on || rx_state);
    end

    // Compare each result word with the oldest prediction
    always @(posedge clk)
    begin
        resolved_t got, want;
        int        i;
        bit        bad;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.collided = m_tdata[0];
            got.moved = m_tdata[1];
            for (i = 0; i < 3; i++)
            begin
                got.n1[i] = m_tdata[2 + 32*i +: 32];
                got.n2[i] = m_tdata[98 + 32*i +: 32];
            end
            if (pending_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word %h", m_tdata);
            end
            else
            begin
                want = pending_q.pop_front();
                bad = (got.collided !== want.collided) || (got.moved !== want.moved);
                for (i = 0; i < 3; i++)
                    bad = bad || (got.n1[i] !== want.n1[i]) || (got.n2[i] !== want.n2[i]);
                if (bad)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp c=%0b m=%0b p1=%0d,%0d,%0d p2=%0d,%0d,%0d",
                                 want.collided, want.moved, want.n1[0], want.n1[1],
                                 want.n1[2], want.n2[0], want.n2[1], want.n2[2],
                                 "  got c=%0b m=%0b p1=%0d,%0d,%0d p2=%0d,%0d,%0d",
                                 got.collided, got.moved, got.n1[0], got.n1[1],
                                 got.n1[2], got.n2[0], got.n2[1], got.n2[2]);
                end
            end
        end
    end

    // Extremes and the named special cases
    task automatic test_directed();
        int mx, mn;
        mx = 32'h7FFF_FFFF;
        mn = 32'h8000_0000;
        send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
        send_pair(make_pair(5, 6, 7, 5, 6, 7, 0, 0));
        send_pair(make_pair(0, 0, 0, 1, 0, 0, 0, 0));
        send_pair(make_pair(0, 0, 0, 3, 0, 0, 1, 2));
        send_pair(make_pair(0, 0, 0, 2, 0, 0, 1, 2));
        send_pair(make_pair(0, 0, 0, 3, 4, 0, 2, 3));
        send_pair(make_pair(0, 0, 0, 3, 4, 0, 3, 3));
        send_pair(make_pair(mn, mn, mn, mx, mx, mx, mx, mx));
        send_pair(make_pair(mx, mx, mx, mn, mn, mn, mx, mx));
        send_pair(make_pair(mn, 0, 0, mx, 0, 0, mx, mx));
        send_pair(make_pair(mn, mn, mn, mn + 10, mn + 10, mn + 10, mx, mx));
        send_pair(make_pair(mx - 10, mx, mx, mx, mx - 10, mx - 3, mx, mx));
        send_pair(make_pair(mx, mx, mx, mx, mx, mx, mx, mx));
        send_pair(make_pair(mn, mn, mn, mn, mn, mn, mx, mx));
        send_pair(make_pair(-1, -1, -1, 1, 1, 1, 1, 1));
        send_pair(make_pair(1, 1, 1, -1, -1, -1, 65536, 65536));
        send_pair(make_pair(0, 0, 0, 0, 0, 1, mx, 0));
        send_pair(make_pair(100, -200, 300, -100, 200, -300, 0, mx));
        send_pair(make_pair(0, 0, 0, 65536, 0, 0, 32768, 32768));
        send_pair(make_pair(0, 0, 0, 65536, 65536, 65536, 65536, 65536));
        send_pair(make_pair(mn, mn, mn, mx, mx, mx, 0, 0));
        send_pair(make_pair(-5, 0, 0, 5, 0, 0, mx, mx));
    endtask

    // Random pairs sent in bursts with random gaps and receiver stalls
    task automatic test_random();
        int n, burst;
        n = 0;
        rx_stall_on = 1'b1;
        while (n < RANDOM_ITEMS)
        begin
            // quiet stretch with no idling on either side
            rx_stall_on = !(n >= 600 && n < 800);
            burst = $urandom_range(1, 20);
            repeat (burst)
            begin
                send_pair(random_pair());
                n++;
            end
            if (rx_stall_on)
                idle_gap($urandom_range(0, 6));
        end
        rx_stall_on = 1'b0;
    endtask

    // Hold the receiver off while the sender keeps offering, so the input stalls
    task automatic test_backpressure();
        hold_reqs <= hold_reqs + 1;
        repeat (200)
            send_pair(random_pair());
    endtask

    // Pause the sender until every result has arrived, then resume
    task automatic test_drain_pause();
        repeat (30)
            send_pair(random_pair());
        wait_drained();
        repeat (30)
            send_pair(random_pair());
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_drain_pause();
        test_backpressure();
        test_random();
        wait_drained();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatches == 0 && pending_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/spcr_pkg.sv
hdl/spcr_isqrt.sv
hdl/spcr_div.sv
hdl/sphere_pair_collide_resolve.sv
tb/sphere_pair_collide_resolve_tb.sv
